/* hw/rtl/ppp_pkg.sv */
// Shared types and codes for the polyline progress projector.
// Depends on nothing; used by ppp_ctrl, ppp_dp, the top level, the checks and the testbench.
package ppp_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = 34;
	localparam int ProdW  = 68;
	localparam int AccW   = 70;
	localparam int AlphaW = 17;
	localparam int AlphaFracW = 16;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_PROJ  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] CFG_ORIGIN_P = 2'd2;

	localparam logic [AlphaW-1:0] ALPHA_ONE = 17'h10000;
	localparam logic [4:0] DIV_STEPS = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_DIFF, ST_LEN_A, ST_LEN_B, ST_DOT_A, ST_DOT_B,
		ST_DIV_INIT, ST_DIV, ST_QX, ST_QY, ST_D2_A, ST_D2_B, ST_PROG,
		ST_UPDATE, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ACCEPT, OP_READ, OP_DIFF, OP_LEN_A, OP_LEN_B, OP_DOT_A,
		OP_DOT_B, OP_DIV_INIT, OP_DIV_STEP, OP_QX, OP_QY, OP_D2_A, OP_D2_B,
		OP_PROG, OP_UPDATE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic div_done;
		logic seg_last;
	} dp_status_t;

endpackage

/* hw/rtl/polyline_progress_projector.sv */
// Top level of the polyline progress projector: sequencer plus datapath.
// Depends on ppp_pkg, ppp_ctrl and ppp_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | cmd, pos_x, pos_y, progress_value
//  out      | out_valid/ out_ready | progress_out, status
//  cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data (origin x, y, progress)
//
// Clear, append and unknown commands go straight to a result, as does an empty
// query. A query walks its n waypoints in turn: each segment runs its products
// one at a time through a single shared multiplier, with the one-bit-a-cycle
// alpha divider after the dot product, skipped when alpha clamps to 0 or 1.
// One request is worked at a time; a new one is taken while the last result
// still waits in the output register, and completes when that slot frees.
// Reset clears the origin, the waypoint count and the handshake state; the
// waypoint memory is never cleared and only filled entries are ever read.
module polyline_progress_projector #(
	parameter int MAX_WAYPOINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] progress_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] progress_out,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ppp_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// configuration registers are always free to take a write
	assign cfg_ready = 1'b1;

	ppp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	ppp_dp #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.dp_status      (dp_status),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.progress_value (progress_value),
		.progress_out   (progress_out),
		.status         (status)
	);

endmodule

/* hw/rtl/ppp_ctrl.sv */
// Sequencer of the polyline progress projector: walks each query segment
// through the datapath steps. Depends on ppp_pkg.
module ppp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           cmd,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ppp_pkg::dp_status_t  dp_status,
	output ppp_pkg::dp_cmd_t     dp_cmd
);
	import ppp_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (dp_cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx    = state_q;
		dp_cmd.op   = OP_NONE;
		dp_cmd.emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dp_cmd.op = OP_ACCEPT;
					state_nx  = (cmd == CMD_QUERY && !dp_status.count_zero) ? ST_READ : ST_DONE;
				end
			end
			ST_READ:     begin dp_cmd.op = OP_READ;     state_nx = ST_DIFF;     end
			ST_DIFF:     begin dp_cmd.op = OP_DIFF;     state_nx = ST_LEN_A;    end
			ST_LEN_A:    begin dp_cmd.op = OP_LEN_A;    state_nx = ST_LEN_B;    end
			ST_LEN_B:    begin dp_cmd.op = OP_LEN_B;    state_nx = ST_DOT_A;    end
			ST_DOT_A:    begin dp_cmd.op = OP_DOT_A;    state_nx = ST_DOT_B;    end
			ST_DOT_B:    begin dp_cmd.op = OP_DOT_B;    state_nx = ST_DIV_INIT; end
			ST_DIV_INIT: begin dp_cmd.op = OP_DIV_INIT; state_nx = ST_DIV;      end
			ST_DIV: begin
				if (dp_status.div_done) begin
					state_nx = ST_QX;
				end else begin
					dp_cmd.op = OP_DIV_STEP;
				end
			end
			ST_QX:       begin dp_cmd.op = OP_QX;       state_nx = ST_QY;       end
			ST_QY:       begin dp_cmd.op = OP_QY;       state_nx = ST_D2_A;     end
			ST_D2_A:     begin dp_cmd.op = OP_D2_A;     state_nx = ST_D2_B;     end
			ST_D2_B:     begin dp_cmd.op = OP_D2_B;     state_nx = ST_PROG;     end
			ST_PROG:     begin dp_cmd.op = OP_PROG;     state_nx = ST_UPDATE;   end
			ST_UPDATE: begin
				dp_cmd.op = OP_UPDATE;
				state_nx  = dp_status.seg_last ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					dp_cmd.emit = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/ppp_dp.sv */
// Datapath of the polyline progress projector: origin registers, waypoint
// memory, shared multiplier, bit-serial divider and result registers. Uses ppp_pkg.
module ppp_dp #(
	parameter int MAX_WAYPOINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppp_pkg::dp_cmd_t    dp_cmd,
	output ppp_pkg::dp_status_t dp_status,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [1:0]          cmd,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  progress_value,
	output logic signed [31:0]  progress_out,
	output logic [1:0]          status
);
	import ppp_pkg::*;

	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	logic signed [CoordW-1:0] wp_x_mem [MAX_WAYPOINTS];
	logic signed [CoordW-1:0] wp_y_mem [MAX_WAYPOINTS];
	logic signed [CoordW-1:0] wp_p_mem [MAX_WAYPOINTS];

	logic signed [CoordW-1:0] origin_x_q, origin_y_q, origin_p_q;
	logic [CW-1:0]            count_q, seg_q;
	logic [4:0]               div_cnt_q;
	logic                     have_q;
	logic                     full;

	logic signed [CoordW-1:0] px_q, py_q, fx_q, fy_q, fp_q, tx_q, ty_q, tp_q;
	logic signed [DiffW-1:0]  dx_q, dy_q, ex0_q, ey0_q, dp_q, ex_q, ey_q;
	logic signed [ProdW-1:0]  m_q;
	logic signed [AccW-1:0]   len2_q, dot_q, d2_q, best_q;
	logic [AccW-2:0]          rem_q;
	logic [AlphaW-1:0]        a_q;
	logic signed [CoordW-1:0] cand_q, res_q, progress_out_q;
	logic [1:0]               res_stat_q, status_q;

	logic signed [DiffW-1:0]  mul_a, mul_b, alpha_ext, q_axis, e_axis;
	logic signed [ProdW-1:0]  prod, prod_sh;
	logic signed [AccW-1:0]   acc_sum;
	logic [AccW-2:0]          rem_sh;
	logic                     rem_ge;

	assign full      = (count_q == CW'(MAX_WAYPOINTS));
	assign alpha_ext = {{(DiffW - AlphaW){1'b0}}, a_q};

	// shared multiplier, operands chosen by the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (dp_cmd.op)
			OP_LEN_A: begin mul_a = dx_q;  mul_b = dx_q;      end
			OP_LEN_B: begin mul_a = dy_q;  mul_b = dy_q;      end
			OP_DOT_A: begin mul_a = ex0_q; mul_b = dx_q;      end
			OP_DOT_B: begin mul_a = ey0_q; mul_b = dy_q;      end
			OP_QX:    begin mul_a = dx_q;  mul_b = alpha_ext; end
			OP_QY:    begin mul_a = dy_q;  mul_b = alpha_ext; end
			OP_D2_A:  begin mul_a = ex_q;  mul_b = ex_q;      end
			OP_D2_B:  begin mul_a = ey_q;  mul_b = ey_q;      end
			OP_PROG:  begin mul_a = dp_q;  mul_b = alpha_ext; end
			default:  begin mul_a = '0;    mul_b = '0;        end
		endcase
	end

	assign prod    = ProdW'(mul_a) * ProdW'(mul_b);
	assign prod_sh = prod >>> AlphaFracW;
	assign acc_sum = AccW'(m_q) + AccW'(prod);
	// projected point on one axis, then the query's offset from it
	assign q_axis  = ((dp_cmd.op == OP_QX) ? DiffW'(fx_q) : DiffW'(fy_q)) + DiffW'(prod_sh);
	assign e_axis  = ((dp_cmd.op == OP_QX) ? DiffW'(px_q) : DiffW'(py_q)) - q_axis;
	assign rem_sh  = {rem_q[AccW-3:0], 1'b0};
	assign rem_ge  = (rem_sh >= len2_q[AccW-2:0]);

	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_ACCEPT && cmd == CMD_APPEND && !full) begin
			wp_x_mem[count_q[IW-1:0]] <= pos_x;
			wp_y_mem[count_q[IW-1:0]] <= pos_y;
			wp_p_mem[count_q[IW-1:0]] <= progress_value;
		end
		if (dp_cmd.op == OP_READ) begin
			tx_q <= wp_x_mem[seg_q[IW-1:0]];
			ty_q <= wp_y_mem[seg_q[IW-1:0]];
			tp_q <= wp_p_mem[seg_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_p_q <= '0;
			count_q    <= '0;
			seg_q      <= '0;
			div_cnt_q  <= '0;
			have_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X: origin_x_q <= cfg_data;
					CFG_ORIGIN_Y: origin_y_q <= cfg_data;
					CFG_ORIGIN_P: origin_p_q <= cfg_data;
					default: ;
				endcase
			end
			case (dp_cmd.op)
				OP_ACCEPT: begin
					if (cmd == CMD_CLEAR) begin
						count_q <= '0;
					end else if (cmd == CMD_APPEND && !full) begin
						count_q <= CW'(count_q + 1'b1);
					end
					seg_q  <= '0;
					have_q <= 1'b0;
				end
				OP_DIV_INIT: begin
					if (len2_q == '0 || dot_q[AccW-1] || dot_q == '0 || dot_q >= len2_q) begin
						div_cnt_q <= '0;
					end else begin
						div_cnt_q <= DIV_STEPS;
					end
				end
				OP_DIV_STEP: div_cnt_q <= div_cnt_q - 5'd1;
				OP_UPDATE: begin
					seg_q <= CW'(seg_q + 1'b1);
					if (!have_q || d2_q < best_q) begin
						have_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_ACCEPT: begin
				px_q <= pos_x;
				py_q <= pos_y;
				fx_q <= origin_x_q;
				fy_q <= origin_y_q;
				fp_q <= origin_p_q;
				res_q <= '0;
				case (cmd)
					CMD_APPEND: res_stat_q <= full ? STAT_FULL : STAT_DONE;
					CMD_QUERY: begin
						if (count_q == '0) begin
							res_q      <= progress_value;
							res_stat_q <= STAT_EMPTY;
						end else begin
							res_stat_q <= STAT_PROJ;
						end
					end
					default: res_stat_q <= STAT_DONE;
				endcase
			end
			OP_DIFF: begin
				dx_q  <= DiffW'(tx_q) - DiffW'(fx_q);
				dy_q  <= DiffW'(ty_q) - DiffW'(fy_q);
				ex0_q <= DiffW'(px_q) - DiffW'(fx_q);
				ey0_q <= DiffW'(py_q) - DiffW'(fy_q);
				dp_q  <= DiffW'(tp_q) - DiffW'(fp_q);
			end
			OP_LEN_A, OP_DOT_A, OP_D2_A: m_q <= prod;
			OP_LEN_B: len2_q <= acc_sum;
			OP_DOT_B: dot_q  <= acc_sum;
			OP_D2_B:  d2_q   <= acc_sum;
			OP_DIV_INIT: begin
				rem_q <= dot_q[AccW-2:0];
				if (len2_q == '0) begin
					a_q <= ALPHA_ONE;
				end else if (dot_q[AccW-1] || dot_q == '0) begin
					a_q <= '0;
				end else if (dot_q >= len2_q) begin
					a_q <= ALPHA_ONE;
				end else begin
					a_q <= '0;
				end
			end
			OP_DIV_STEP: begin
				rem_q <= rem_ge ? (rem_sh - len2_q[AccW-2:0]) : rem_sh;
				a_q   <= {a_q[AlphaW-2:0], rem_ge};
			end
			OP_QX: ex_q <= e_axis;
			OP_QY: ey_q <= e_axis;
			OP_PROG: cand_q <= fp_q + prod_sh[CoordW-1:0];
			OP_UPDATE: begin
				if (!have_q || d2_q < best_q) begin
					best_q <= d2_q;
					res_q  <= cand_q;
				end
				fx_q <= tx_q;
				fy_q <= ty_q;
				fp_q <= tp_q;
			end
			default: ;
		endcase
		if (dp_cmd.emit) begin
			progress_out_q <= res_q;
			status_q       <= res_stat_q;
		end
	end

	assign dp_status.count_zero = (count_q == '0);
	assign dp_status.div_done   = (div_cnt_q == '0);
	assign dp_status.seg_last   = (CW'(seg_q + 1'b1) == count_q);

	assign progress_out = progress_out_q;
	assign status       = status_q;

endmodule

/* hw/rtl/ppp_checker.sv */
// Port-level checks for the polyline progress projector, bound to the top.
// Depends on ppp_pkg for the status codes.
module ppp_assertions (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] progress_out,
	input logic [1:0]         status,
	input logic               cfg_ready
);
	import ppp_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(progress_out) && $stable(status))
		else $error("stalled result changed");

	// table operations and a full table report zero progress
	a_zero_prog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_DONE || status == STAT_FULL) |-> progress_out == '0)
		else $error("table result carries progress");

	// a new result only appears after the block was busy with its request
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in work");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind polyline_progress_projector ppp_assertions u_ppp_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.progress_out (progress_out),
	.status       (status),
	.cfg_ready    (cfg_ready)
);

/* tb/ppp_checker.sv */
// Checker for the polyline progress projector: watches the request, result and
// register channels, predicts each result and compares it. Depends on ppp_pkg.
module ppp_checker
	import ppp_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] progress_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] progress_out,
	input  logic [1:0]         status,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] progress;
		logic [1:0]  stat;
	} route_result_t;

	route_result_t progress_due[$];

	logic signed [31:0] org_x, org_y, org_p;
	logic signed [31:0] wp_x [MAX_WAYPOINTS];
	logic signed [31:0] wp_y [MAX_WAYPOINTS];
	logic signed [31:0] wp_p [MAX_WAYPOINTS];
	int                 wp_count;

	// Projection onto each segment with alpha truncated to 16 fraction bits; earlier segment keeps a tie.
	function automatic logic [31:0] nearest_progress(input logic signed [31:0] qx_in,
			input logic signed [31:0] qy_in);
		logic signed [127:0] fx, fy, fp, tx, ty, tp, dx, dy, len2, dot, a;
		logic signed [127:0] px, py, qx, qy, ex, ey, d2, best, res;
		bit have;
		fx = org_x; fy = org_y; fp = org_p;
		px = qx_in; py = qy_in;
		have = 0; best = 0; res = 0;
		for (int i = 0; i < wp_count; i++) begin
			tx = wp_x[i]; ty = wp_y[i]; tp = wp_p[i];
			dx = tx - fx;
			dy = ty - fy;
			len2 = dx * dx + dy * dy;
			dot = (px - fx) * dx + (py - fy) * dy;
			if (len2 == 0)
				a = 65536;
			else if (dot <= 0)
				a = 0;
			else if (dot >= len2)
				a = 65536;
			else
				a = (dot <<< 16) / len2;
			qx = fx + ((dx * a) >>> 16);
			qy = fy + ((dy * a) >>> 16);
			ex = px - qx;
			ey = py - qy;
			d2 = ex * ex + ey * ey;
			if (!have || d2 < best) begin
				have = 1;
				best = d2;
				res = fp + (((tp - fp) * a) >>> 16);
			end
			fx = tx; fy = ty; fp = tp;
		end
		return res[31:0];
	endfunction

	assign pending = progress_due.size();

	always @(posedge clk or negedge arst_n) begin
		route_result_t exp_r;
		route_result_t got;
		if (!arst_n) begin
			org_x <= 0;
			org_y <= 0;
			org_p <= 0;
			wp_count = 0;
			errors = 0;
			progress_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = '{progress_out, status};
				if (progress_due.size() == 0) begin
					errors++;
					$display("%0t: result with nothing due: progress %h status %0d",
						$time, progress_out, status);
				end else begin
					exp_r = progress_due.pop_front();
					if (exp_r.progress !== got.progress) begin
						errors++;
						$display("%0t: progress expected %h actual %h",
							$time, exp_r.progress, got.progress);
					end
					if (exp_r.stat !== got.stat) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.stat, got.stat);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIGIN_X: org_x <= cfg_data;
					CFG_ORIGIN_Y: org_y <= cfg_data;
					CFG_ORIGIN_P: org_p <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				exp_r = '{32'd0, STAT_DONE};
				case (cmd)
					CMD_CLEAR: wp_count = 0;
					CMD_APPEND: begin
						if (wp_count < MAX_WAYPOINTS) begin
							wp_x[wp_count] = pos_x;
							wp_y[wp_count] = pos_y;
							wp_p[wp_count] = progress_value;
							wp_count++;
						end else
							exp_r.stat = STAT_FULL;
					end
					CMD_QUERY: begin
						if (wp_count == 0)
							exp_r = '{progress_value, STAT_EMPTY};
						else
							exp_r = '{nearest_progress(pos_x, pos_y), STAT_PROJ};
					end
					default: ;
				endcase
				progress_due.push_back(exp_r);
			end
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the polyline progress projector testbench: clock, reset, stimulus and
// verdict. Depends on ppp_pkg, polyline_progress_projector and ppp_checker.
module testbench;
	import ppp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         cmd = CMD_CLEAR;
	logic signed [31:0] pos_x = 0;
	logic signed [31:0] pos_y = 0;
	logic signed [31:0] progress_value = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [31:0] progress_out;
	logic [1:0]         status;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_ORIGIN_X;
	logic [31:0]        cfg_data = 0;

	int errors, pending;
	int idle_pct = 0;      // chance of a gap before each request
	int stall_pct = 0;     // chance the result side holds off in a cycle
	logic hold_start = 0;  // pulse: hold the result side off for a long stretch
	int hold_cnt;
	int sent = 0;

	polyline_progress_projector uut (.*);

	ppp_checker chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Give up well past the slowest legal run.
	initial begin
		#250ms;
		$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off counted here on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			hold_cnt <= 0;
		end else if (hold_start) begin
			out_ready <= 0;
			hold_cnt <= 400;
		end else if (hold_cnt > 0) begin
			out_ready <= 0;
			hold_cnt <= hold_cnt - 1;
		end else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Offer one request; hold it until taken. Sample ready at the falling edge.
	task automatic send(input logic [1:0] c, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] p);
		bit taken;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		progress_value <= p;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	// Drop valid and wait for every due result before touching registers.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		bit taken;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			2: return $urandom_range(0, 2000000) - 1000000;
			default: return ($urandom_range(0, 400) - 200) << 16 | $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic set_origin(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] p);
		write_reg(CFG_ORIGIN_X, x);
		write_reg(CFG_ORIGIN_Y, y);
		write_reg(CFG_ORIGIN_P, p);
	endtask

	// One route: mostly a clear, waypoints, then queries with a little noise.
	task automatic route_burst();
		int n;
		if ($urandom_range(0, 9) != 0)
			send(CMD_CLEAR, $urandom, $urandom, $urandom);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send(CMD_APPEND, pick_coord(), pick_coord(), pick_coord());
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9))
				0: send(CMD_UNUSED, $urandom, $urandom, $urandom);
				1: send(CMD_APPEND, pick_coord(), pick_coord(), pick_coord());
				default: send(CMD_QUERY, pick_coord(), pick_coord(), $urandom);
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, unused command, zero-length segment, ties, full table.
		send(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send(CMD_APPEND, 0, 0, 32'h0001_0000);
		send(CMD_QUERY, 32'h0005_0000, 0, 0);
		send(CMD_APPEND, 32'h0002_0000, 0, 32'h0003_0000);
		send(CMD_APPEND, 0, 0, 32'h0007_0000);
		send(CMD_QUERY, 32'h0001_0000, 32'h0001_0000, 0);
		send(CMD_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 0);
		send(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_QUERY, 0, 0, 32'h1234_5678);
		for (int i = 0; i < 65; i++)
			send(CMD_APPEND, pick_coord(), pick_coord(), pick_coord());
		send(CMD_QUERY, pick_coord(), pick_coord(), 0);
		drain();

		// Random phases, each under a fresh origin; extremes first.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  set_origin(32'h8000_0000,
					32'h8000_0000, 32'h8000_0000); end
				1: begin idle_pct = 47; stall_pct = 0;  set_origin(32'h7fff_ffff,
					32'h7fff_ffff, 32'h7fff_ffff); end
				2: begin idle_pct = 0;  stall_pct = 47; set_origin(pick_coord(),
					pick_coord(), $urandom); end
				3: begin idle_pct = 8;  stall_pct = 8;  set_origin(0, 0, 0); end
				default: begin idle_pct = 0; stall_pct = 0; set_origin($urandom,
					$urandom, $urandom); end
			endcase
			// Long hold-off on the result side while requests keep coming.
			if (ph == 4) begin
				hold_start <= 1;
				@(posedge clk);
				hold_start <= 0;
			end
			while (sent < 400 * (ph + 1) + 100) begin
				route_burst();
				// Now and then pause until every due result is back.
				if ($urandom_range(0, 29) == 0) drain();
			end
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
